// File: rtl/core/trivium_byte_stream_cipher_defines.svh
// assertion macros for the trivium byte stream cipher
// included by the top level; no other dependencies
`ifndef TRIVIUM_BYTE_STREAM_CIPHER_DEFINES_SVH
`define TRIVIUM_BYTE_STREAM_CIPHER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define TRIV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trivium assertion failed");

// next-cycle implication, disabled in reset
`define TRIV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trivium assertion failed");

`else

`define TRIV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TRIV_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/triv_pkg.sv
// shared types and constants for the trivium byte stream cipher
// no dependencies; imported by every module of the block
package triv_pkg;

    localparam int LEN_A            = 93;
    localparam int LEN_B            = 84;
    localparam int LEN_C            = 111;
    localparam int KEY_BITS         = 80;
    localparam int CFG_WIDTH        = 64;
    localparam int HIGH_WIDTH       = KEY_BITS - CFG_WIDTH;
    localparam int CFG_IDX_WIDTH    = 2;
    localparam int BYTE_WIDTH       = 8;
    localparam int ROUNDS_PER_CYCLE = 8;
    localparam int WARMUP_ROUNDS    = 1152;
    localparam int WARMUP_CYCLES    = WARMUP_ROUNDS / ROUNDS_PER_CYCLE;
    localparam int WARM_CNT_WIDTH   = $clog2(WARMUP_CYCLES);

    // full 288-bit cipher state, index j of each register is s(base+j)
    typedef struct packed {
        logic [LEN_A-1:0] a;
        logic [LEN_B-1:0] b;
        logic [LEN_C-1:0] c;
    } triv_state_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_KEY_LOW  = 2'd0,
        CFG_KEY_HIGH = 2'd1,
        CFG_IV_LOW   = 2'd2,
        CFG_IV_HIGH  = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        ACT_INIT    = 1'b0,
        ACT_ENCRYPT = 1'b1
    } action_t;

    typedef enum logic {
        ST_RUN  = 1'b0,
        ST_WARM = 1'b1
    } ctrl_state_t;

endpackage

// File: rtl/core/triv_round.sv
// one trivium round cell: shifts the three registers by one and emits a keystream bit
// depends on triv_pkg
module triv_round (
    input  triv_pkg::triv_state_t st_in,
    output triv_pkg::triv_state_t st_out,
    output logic                  z
);
    import triv_pkg::*;

    logic t1;
    logic t2;
    logic t3;
    logic t1_fb;
    logic t2_fb;
    logic t3_fb;

    // linear taps and keystream bit
    assign t1 = st_in.a[65] ^ st_in.a[92];
    assign t2 = st_in.b[68] ^ st_in.b[83];
    assign t3 = st_in.c[65] ^ st_in.c[110];
    assign z  = t1 ^ t2 ^ t3;

    // nonlinear feedback into the neighbor register
    assign t1_fb = t1 ^ (st_in.a[90] & st_in.a[91]) ^ st_in.b[77];
    assign t2_fb = t2 ^ (st_in.b[81] & st_in.b[82]) ^ st_in.c[86];
    assign t3_fb = t3 ^ (st_in.c[108] & st_in.c[109]) ^ st_in.a[68];

    // shift each register up by one
    assign st_out.a = {st_in.a[LEN_A-2:0], t3_fb};
    assign st_out.b = {st_in.b[LEN_B-2:0], t1_fb};
    assign st_out.c = {st_in.c[LEN_C-2:0], t2_fb};

endmodule

// File: rtl/core/triv_round_chain.sv
// row of round cells advancing the state eight rounds per clock
// depends on triv_pkg and triv_round
module triv_round_chain (
    input  triv_pkg::triv_state_t                     st_in,
    output triv_pkg::triv_state_t                     st_out,
    output logic [triv_pkg::ROUNDS_PER_CYCLE-1:0]     ks
);
    import triv_pkg::*;

    triv_state_t st_link [ROUNDS_PER_CYCLE+1];
    logic [ROUNDS_PER_CYCLE-1:0] z_bits;

    assign st_link[0] = st_in;

    // each cell hands its state to the next one
    for (genvar i = 0; i < ROUNDS_PER_CYCLE; i++) begin : g_cell
        triv_round u_round (
            .st_in  (st_link[i]),
            .st_out (st_link[i+1]),
            .z      (z_bits[i])
        );
        // first round lands in the msb
        assign ks[ROUNDS_PER_CYCLE-1-i] = z_bits[i];
    end

    assign st_out = st_link[ROUNDS_PER_CYCLE];

endmodule

// File: rtl/core/trivium_byte_stream_cipher.sv
// Trivium stream cipher, one byte per transaction. In an encrypt transaction
// (action = 1) a row of eight round cells advances the 288-bit state
// eight rounds and the data byte is XORed with the eight keystream bits
// (first bit in the msb) into an output register, so a new byte can be
// accepted every cycle while the previous result is taken.
// An initialize transaction (action = 0) loads the key and IV from the
// configuration registers and then runs 1152 warm-up rounds through the
// same cell row, during which in_ready stays low; it returns no result.
// Configuration writes take effect at the next initialize.
`include "trivium_byte_stream_cipher_defines.svh"

module trivium_byte_stream_cipher (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [triv_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [triv_pkg::CFG_WIDTH-1:0]       cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 action,
    input  logic [triv_pkg::BYTE_WIDTH-1:0]      data_byte,
    // output channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [triv_pkg::BYTE_WIDTH-1:0]      cipher_byte
);
    import triv_pkg::*;

    logic [CFG_WIDTH-1:0]      key_low_reg;
    logic [HIGH_WIDTH-1:0]     key_high_reg;
    logic [CFG_WIDTH-1:0]      iv_low_reg;
    logic [HIGH_WIDTH-1:0]     iv_high_reg;

    ctrl_state_t               state_reg;
    ctrl_state_t               state_next;
    logic [WARM_CNT_WIDTH-1:0] warm_cnt_reg;
    logic [WARM_CNT_WIDTH-1:0] warm_cnt_next;
    triv_state_t               triv_reg;
    triv_state_t               triv_next;
    triv_state_t               triv_adv;
    triv_state_t               triv_load;
    logic [BYTE_WIDTH-1:0]     ks;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [BYTE_WIDTH-1:0]     cipher_byte_reg;
    logic [BYTE_WIDTH-1:0]     cipher_byte_next;

    logic                      in_fire;
    logic                      init_fire;
    logic                      enc_fire;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            iv_low_reg   <= '0;
            iv_high_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                CFG_KEY_HIGH: key_high_reg <= cfg_data[HIGH_WIDTH-1:0];
                CFG_IV_LOW:   iv_low_reg   <= cfg_data;
                CFG_IV_HIGH:  iv_high_reg  <= cfg_data[HIGH_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // eight rounds per clock
    triv_round_chain u_chain (
        .st_in  (triv_reg),
        .st_out (triv_adv),
        .ks     (ks)
    );

    // key and iv load image, three ones at the top of register c
    assign triv_load.a = {{(LEN_A-KEY_BITS){1'b0}}, key_high_reg, key_low_reg};
    assign triv_load.b = {{(LEN_B-KEY_BITS){1'b0}}, iv_high_reg, iv_low_reg};
    assign triv_load.c = {3'b111, {(LEN_C-3){1'b0}}};

    // handshake
    assign in_ready  = (state_reg == ST_RUN) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign init_fire = in_fire && (action_t'(action) == ACT_INIT);
    assign enc_fire  = in_fire && (action_t'(action) == ACT_ENCRYPT);

    // control, state update and output register next values
    always_comb
    begin
        state_next       = state_reg;
        warm_cnt_next    = warm_cnt_reg;
        triv_next        = triv_reg;
        out_valid_next   = out_valid_reg;
        cipher_byte_next = cipher_byte_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_RUN:
            begin
                if (init_fire)
                begin
                    triv_next     = triv_load;
                    state_next    = ST_WARM;
                    warm_cnt_next = WARM_CNT_WIDTH'(WARMUP_CYCLES - 1);
                end
                else if (enc_fire)
                begin
                    triv_next        = triv_adv;
                    out_valid_next   = 1'b1;
                    cipher_byte_next = data_byte ^ ks;
                end
            end
            ST_WARM:
            begin
                triv_next = triv_adv;
                if (warm_cnt_reg == '0)
                begin
                    state_next = ST_RUN;
                end
                else
                begin
                    warm_cnt_next = warm_cnt_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // control registers and cipher state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            warm_cnt_reg  <= '0;
            triv_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            warm_cnt_reg  <= warm_cnt_next;
            triv_reg      <= triv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        cipher_byte_reg <= cipher_byte_next;
    end

    assign out_valid   = out_valid_reg;
    assign cipher_byte = cipher_byte_reg;

    // checks
    `TRIV_ASSERT_IMP(a_no_accept_in_warmup, clk, rst_n, in_ready, state_reg == ST_RUN)
    `TRIV_ASSERT_NEXT(a_init_starts_warmup, clk, rst_n, init_fire, (state_reg == ST_WARM) && (warm_cnt_reg == WARM_CNT_WIDTH'(WARMUP_CYCLES - 1)))
    `TRIV_ASSERT_NEXT(a_encrypt_gives_result, clk, rst_n, enc_fire, out_valid)
    `TRIV_ASSERT_NEXT(a_warmup_ends, clk, rst_n, (state_reg == ST_WARM) && (warm_cnt_reg == '0), state_reg == ST_RUN)

endmodule

// File: tb/tb_trivium_byte_stream_cipher.sv
// self-checking testbench for the trivium byte stream cipher
// depends on triv_pkg and trivium_byte_stream_cipher; keeps its own copy of the
// 288-bit state to predict every cipher byte, under random idling on both channels
module tb_trivium_byte_stream_cipher;
    timeunit 1ns;
    timeprecision 1ps;

    import triv_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = WARMUP_CYCLES + 16;
    localparam int STALL_LIMIT   = 4000;
    localparam int LONG_HOLD     = 300;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 200;
    localparam int INIT_PCT      = 3;
    localparam int MAX_PRINTS    = 30;
    localparam int DIR_ROWS      = 28;

    typedef enum logic {
        ROW_ITEM,
        ROW_WRITE
    } row_kind_t;

    // one row of the directed stimulus: either a register write or a transaction
    typedef struct packed {
        row_kind_t              kind;
        cfg_idx_t               reg_idx;
        logic [CFG_WIDTH-1:0]   value;
        action_t                act;
        logic [BYTE_WIDTH-1:0]  data;
        logic                   typed;
        logic [BYTE_WIDTH-1:0]  cipher;
    } dir_row_t;

    // block inputs, all known from time zero
    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_IDX_WIDTH-1:0]   cfg_index = CFG_KEY_LOW;
    logic [CFG_WIDTH-1:0]       cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       action = ACT_ENCRYPT;
    logic [BYTE_WIDTH-1:0]      data_byte = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [BYTE_WIDTH-1:0]      cipher_byte;

    // predictor state and its copy of the key and iv registers
    triv_state_t                keystate = '0;
    logic [CFG_WIDTH-1:0]       key_low_r = '0;
    logic [HIGH_WIDTH-1:0]      key_high_r = '0;
    logic [CFG_WIDTH-1:0]       iv_low_r = '0;
    logic [HIGH_WIDTH-1:0]      iv_high_r = '0;

    logic [BYTE_WIDTH-1:0]      cipher_expected [$];

    int                         tx_idle_pct = 15;
    int                         rx_idle_pct = 59;
    bit                         hold_req = 1'b0;
    int                         mismatch_count = 0;
    int                         sent_count = 0;
    int                         init_count = 0;
    int                         checked_count = 0;
    int                         setting_count = 0;

    dir_row_t                   dir_rows [DIR_ROWS];

    trivium_byte_stream_cipher dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cipher_byte (cipher_byte)
    );

    // clock
    always #CLK_HALF clk = ~clk;

    // one line per mismatch, printing capped
    task automatic report_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
        begin
            $display("[%0t] error: %s", $realtime, msg);
        end
    endtask

    // one trivium round on the predictor state, z is the keystream bit
    task automatic cipher_round(output logic z);
        logic t1;
        logic t2;
        logic t3;
        t1 = keystate.a[65] ^ keystate.a[92];
        t2 = keystate.b[68] ^ keystate.b[83];
        t3 = keystate.c[65] ^ keystate.c[110];
        z  = t1 ^ t2 ^ t3;
        t1 = t1 ^ (keystate.a[90] & keystate.a[91]) ^ keystate.b[77];
        t2 = t2 ^ (keystate.b[81] & keystate.b[82]) ^ keystate.c[86];
        t3 = t3 ^ (keystate.c[108] & keystate.c[109]) ^ keystate.a[68];
        keystate.a = {keystate.a[LEN_A-2:0], t3};
        keystate.b = {keystate.b[LEN_B-2:0], t1};
        keystate.c = {keystate.c[LEN_C-2:0], t2};
    endtask

    // next state and cipher byte for one accepted transaction
    task automatic predict_item(input action_t act, input logic [BYTE_WIDTH-1:0] plain,
                                output logic produced, output logic [BYTE_WIDTH-1:0] cipher);
        logic                  z;
        logic [BYTE_WIDTH-1:0] stream;
        int                    r;
        produced = 1'b0;
        cipher   = '0;
        stream   = '0;
        if (act == ACT_INIT)
        begin
            // key into s1..s80, iv into s94..s173, three ones at the top of c
            keystate = '0;
            keystate.a[KEY_BITS-1:0] = {key_high_r, key_low_r};
            keystate.b[KEY_BITS-1:0] = {iv_high_r, iv_low_r};
            keystate.c[LEN_C-1 -: 3] = 3'b111;
            for (r = 0; r < WARMUP_ROUNDS; r++)
            begin
                cipher_round(z);
            end
        end
        else
        begin
            // first keystream bit lands in the msb
            for (r = 0; r < BYTE_WIDTH; r++)
            begin
                cipher_round(z);
                stream[BYTE_WIDTH-1-r] = z;
            end
            cipher   = stream ^ plain;
            produced = 1'b1;
        end
    endtask

    // register write, with the write enable dropped again before the task returns
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_WIDTH-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_KEY_LOW:  key_low_r  = value;
            CFG_KEY_HIGH: key_high_r = value[HIGH_WIDTH-1:0];
            CFG_IV_LOW:   iv_low_r   = value;
            CFG_IV_HIGH:  iv_high_r  = value[HIGH_WIDTH-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // offer one transaction and predict it once accepted
    task automatic send_item(input action_t act, input logic [BYTE_WIDTH-1:0] plain,
                             input logic typed, input logic [BYTE_WIDTH-1:0] typed_cipher);
        logic                  produced;
        logic [BYTE_WIDTH-1:0] predicted;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        data_byte <= plain;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        predict_item(act, plain, produced, predicted);
        if (produced)
        begin
            cipher_expected.push_back(typed ? typed_cipher : predicted);
        end
        sent_count++;
        if (act == ACT_INIT)
        begin
            init_count++;
        end
    endtask

    // sender stops and waits for every outstanding cipher byte
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (cipher_expected.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // drained, then long enough for a warm-up still running
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic dir_row_t item_row(input action_t act, input logic [BYTE_WIDTH-1:0] data,
                                          input logic typed, input logic [BYTE_WIDTH-1:0] cipher);
        dir_row_t row;
        row        = '0;
        row.kind   = ROW_ITEM;
        row.act    = act;
        row.data   = data;
        row.typed  = typed;
        row.cipher = cipher;
        return row;
    endfunction

    function automatic dir_row_t write_row(input cfg_idx_t idx, input logic [CFG_WIDTH-1:0] value);
        dir_row_t row;
        row         = '0;
        row.kind    = ROW_WRITE;
        row.reg_idx = idx;
        row.value   = value;
        return row;
    endfunction

    // receiver: random ready, long hold on request, compares every output transaction
    initial
    begin
        logic [BYTE_WIDTH-1:0] want;
        int                    hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (cipher_expected.size() == 0)
                begin
                    report_error($sformatf("cipher byte %02h with nothing expected", cipher_byte));
                end
                else
                begin
                    want = cipher_expected.pop_front();
                    checked_count++;
                    if (cipher_byte !== want)
                    begin
                        report_error($sformatf("cipher_byte %02h, expected %02h",
                                               cipher_byte, want));
                    end
                end
            end
            if (hold_req && hold_left == 0)
            begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // watchdog on cycles without any transaction
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("tb_trivium_byte_stream_cipher failed");
        $finish;
    end

    // main sequence
    initial
    begin
        logic [CFG_WIDTH-1:0] setting [4];
        action_t              act;
        bit                   prev_write;
        int                   i;
        int                   phase;
        int                   n;

        // all-zero state gives a zero keystream until the first initialize
        dir_rows[0]  = item_row(ACT_ENCRYPT, 8'h00, 1'b1, 8'h00);
        dir_rows[1]  = item_row(ACT_ENCRYPT, 8'hFF, 1'b1, 8'hFF);
        dir_rows[2]  = item_row(ACT_ENCRYPT, 8'hA5, 1'b1, 8'hA5);
        dir_rows[3]  = item_row(ACT_ENCRYPT, 8'h5A, 1'b1, 8'h5A);
        // zero key and iv from reset
        dir_rows[4]  = item_row(ACT_INIT,    8'h00, 1'b0, 8'h00);
        dir_rows[5]  = item_row(ACT_ENCRYPT, 8'h00, 1'b0, 8'h00);
        dir_rows[6]  = item_row(ACT_ENCRYPT, 8'hFF, 1'b0, 8'h00);
        dir_rows[7]  = item_row(ACT_ENCRYPT, 8'h80, 1'b0, 8'h00);
        // all-ones key and iv, upper bits of the high registers dropped
        dir_rows[8]  = write_row(CFG_KEY_LOW,  '1);
        dir_rows[9]  = write_row(CFG_KEY_HIGH, '1);
        dir_rows[10] = write_row(CFG_IV_LOW,   '1);
        dir_rows[11] = write_row(CFG_IV_HIGH,  '1);
        // new registers do not touch the running stream
        dir_rows[12] = item_row(ACT_ENCRYPT, 8'h01, 1'b0, 8'h00);
        dir_rows[13] = item_row(ACT_INIT,    8'hFF, 1'b0, 8'h00);
        dir_rows[14] = item_row(ACT_ENCRYPT, 8'h00, 1'b0, 8'h00);
        dir_rows[15] = item_row(ACT_ENCRYPT, 8'hFF, 1'b0, 8'h00);
        // back-to-back initialize
        dir_rows[16] = item_row(ACT_INIT,    8'h3C, 1'b0, 8'h00);
        dir_rows[17] = item_row(ACT_INIT,    8'hC3, 1'b0, 8'h00);
        dir_rows[18] = item_row(ACT_ENCRYPT, 8'h7F, 1'b0, 8'h00);
        // mixed key and iv patterns
        dir_rows[19] = write_row(CFG_KEY_LOW,  64'h0123_4567_89AB_CDEF);
        dir_rows[20] = write_row(CFG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_0001);
        dir_rows[21] = write_row(CFG_IV_LOW,   64'h8000_0000_0000_0001);
        dir_rows[22] = write_row(CFG_IV_HIGH,  64'h0000_0000_0000_8000);
        dir_rows[23] = item_row(ACT_INIT,    8'h00, 1'b0, 8'h00);
        dir_rows[24] = item_row(ACT_ENCRYPT, 8'h00, 1'b0, 8'h00);
        dir_rows[25] = item_row(ACT_ENCRYPT, 8'hFF, 1'b0, 8'h00);
        dir_rows[26] = item_row(ACT_ENCRYPT, 8'h55, 1'b0, 8'h00);
        dir_rows[27] = item_row(ACT_ENCRYPT, 8'hAA, 1'b0, 8'h00);

        // reset
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        prev_write = 1'b1;
        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].kind == ROW_WRITE)
            begin
                if (!prev_write)
                begin
                    settle();
                end
                write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
                prev_write = 1'b1;
            end
            else
            begin
                send_item(dir_rows[i].act, dir_rows[i].data, dir_rows[i].typed,
                          dir_rows[i].cipher);
                prev_write = 1'b0;
            end
        end
        setting_count = 3;

        // random phases, each with its own key and iv
        for (phase = 0; phase < PHASES; phase++)
        begin
            settle();
            if (phase < 2)
            begin
                tx_idle_pct = 15;
                rx_idle_pct = 59;
            end
            else if (phase < 4)
            begin
                tx_idle_pct = 59;
                rx_idle_pct = 15;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (i = 0; i < 4; i++)
            begin
                if (phase == 0)
                begin
                    setting[i] = '0;
                end
                else if (phase == 1)
                begin
                    setting[i] = '1;
                end
                else
                begin
                    setting[i] = {$urandom, $urandom};
                end
            end
            write_reg(CFG_KEY_LOW,  setting[0]);
            write_reg(CFG_KEY_HIGH, setting[1]);
            write_reg(CFG_IV_LOW,   setting[2]);
            write_reg(CFG_IV_HIGH,  setting[3]);
            setting_count++;

            send_item(ACT_INIT, BYTE_WIDTH'($urandom_range(255)), 1'b0, 8'h00);
            for (n = 1; n < PHASE_ITEMS; n++)
            begin
                // receiver stalls long while the sender keeps offering
                if (phase == 2 && n == 40)
                begin
                    hold_req = 1'b1;
                end
                // sender waits for the pipeline to empty
                if (phase == 3 && n == 100)
                begin
                    drain_results();
                end
                act = ($urandom_range(99) < INIT_PCT) ? ACT_INIT : ACT_ENCRYPT;
                send_item(act, BYTE_WIDTH'($urandom_range(255)), 1'b0, 8'h00);
            end
        end

        // end of run
        settle();
        if (cipher_expected.size() != 0)
        begin
            report_error($sformatf("%0d cipher bytes never arrived", cipher_expected.size()));
        end
        $display("run covered %0d transactions with %0d initializations under %0d key/iv settings",
                 sent_count, init_count, setting_count);
        $display("%0d cipher bytes compared, %0d mismatches", checked_count, mismatch_count);
        if (mismatch_count == 0)
        begin
            $display("tb_trivium_byte_stream_cipher passed");
        end
        else
        begin
            $display("tb_trivium_byte_stream_cipher failed");
        end
        $finish;
    end

endmodule
